// ===== src/chdr_pkg.sv =====
// Shared types and constants for the ChaCha double round permutation core.
// No dependencies.
package chdr_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int WORD_COUNT  = 16;
   localparam int FIELD_COUNT = 8;
   localparam int LANE_COUNT  = 4;

   localparam int ROT_A = 16;
   localparam int ROT_B = 12;
   localparam int ROT_C = 8;
   localparam int ROT_D = 7;

   localparam logic [3:0] COUNT_RESET = 4'd10;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // four words that one quarter round works on
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

endpackage

// ===== src/chdr_quarter_round.sv =====
// One ChaCha quarter round: add, xor, rotate by 16, 12, 8 and 7.
// Depends on chdr_pkg.
module chdr_quarter_round
   import chdr_pkg::*;
(
   input  quad_type quad_i,
   output quad_type quad_o
);

   function automatic word_type rotl(input word_type x, input int s);
      rotl = (x << s) | (x >> (WORD_WIDTH - s));
   endfunction

   word_type a1, b1, c1, d1, a2, b2, c2, d2;

   always_comb begin
      a1 = quad_i.a + quad_i.b;
      d1 = rotl(quad_i.d ^ a1, ROT_A);
      c1 = quad_i.c + d1;
      b1 = rotl(quad_i.b ^ c1, ROT_B);
      a2 = a1 + b1;
      d2 = rotl(d1 ^ a2, ROT_C);
      c2 = c1 + d2;
      b2 = rotl(b1 ^ c2, ROT_D);
      quad_o = '{a: a2, b: b2, c: c2, d: d2};
   end

endmodule

// ===== src/chacha_double_round_permutation_core.sv =====
// ChaCha double round permutation core, 512-bit state in, 512-bit state out.
// Each of the N double rounds is a column pass, then a diagonal pass, one per
// cycle through four quarter round lanes; the result is then flushed into the
// output register, waiting while that register still holds an untaken result.
// A new item is taken only once the last one is flushed: a single shared pass unit.
// Reset (synchronous, high): sequencer idle, output empty, round count to 10.
module chacha_double_round_permutation_core
   import chdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_words_0_1,
   input  logic [63:0] req_words_2_3,
   input  logic [63:0] req_words_4_5,
   input  logic [63:0] req_words_6_7,
   input  logic [63:0] req_words_8_9,
   input  logic [63:0] req_words_10_11,
   input  logic [63:0] req_words_12_13,
   input  logic [63:0] req_words_14_15,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_words_0_1,
   output logic [63:0] rsp_out_words_2_3,
   output logic [63:0] rsp_out_words_4_5,
   output logic [63:0] rsp_out_words_6_7,
   output logic [63:0] rsp_out_words_8_9,
   output logic [63:0] rsp_out_words_10_11,
   output logic [63:0] rsp_out_words_12_13,
   output logic [63:0] rsp_out_words_14_15,

   input  logic        csr_write_en,
   input  logic [3:0]  csr_write_data
);

   // Sequencer and round bookkeeping
   state_type   state_ff, state_in;
   logic [3:0]  count_ff;           // configured double rounds
   logic [3:0]  rounds_ff, rounds_in; // double rounds finished for this item
   logic        diag_ff, diag_in;   // 0: column pass next, 1: diagonal pass next

   // Working state, loaded on accept, rewritten by every pass
   word_type    work_ff [WORD_COUNT];
   word_type    work_in [WORD_COUNT];
   word_type    pass_words [WORD_COUNT];

   // Output holding register, parts the result side from the sequencer
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] out_ff [FIELD_COUNT];
   logic        load_out;

   logic [63:0] req_fields [FIELD_COUNT];

   // Lane operands and results of the shared pass unit
   quad_type    lane_in  [LANE_COUNT];
   quad_type    lane_out [LANE_COUNT];

   assign req_fields[0] = req_words_0_1;
   assign req_fields[1] = req_words_2_3;
   assign req_fields[2] = req_words_4_5;
   assign req_fields[3] = req_words_6_7;
   assign req_fields[4] = req_words_8_9;
   assign req_fields[5] = req_words_10_11;
   assign req_fields[6] = req_words_12_13;
   assign req_fields[7] = req_words_14_15;

   // Operand routing. Column pass: lane i takes words i, 4+i, 8+i, 12+i.
   // Diagonal pass: rows b, c, d are rotated left by one, two, three lanes.
   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         lane_in[i].a = work_ff[i];
         if (diag_ff) begin
            lane_in[i].b = work_ff[4  + ((i + 1) & 3)];
            lane_in[i].c = work_ff[8  + ((i + 2) & 3)];
            lane_in[i].d = work_ff[12 + ((i + 3) & 3)];
         end else begin
            lane_in[i].b = work_ff[4  + i];
            lane_in[i].c = work_ff[8  + i];
            lane_in[i].d = work_ff[12 + i];
         end
      end
   end

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      chdr_quarter_round u_qr (
         .quad_i (lane_in[g]),
         .quad_o (lane_out[g])
      );
   end

   // Write back each lane result to the words it was taken from
   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         pass_words[i] = lane_out[i].a;
         if (diag_ff) begin
            pass_words[4  + ((i + 1) & 3)] = lane_out[i].b;
            pass_words[8  + ((i + 2) & 3)] = lane_out[i].c;
            pass_words[12 + ((i + 3) & 3)] = lane_out[i].d;
         end else begin
            pass_words[4  + i] = lane_out[i].b;
            pass_words[8  + i] = lane_out[i].c;
            pass_words[12 + i] = lane_out[i].d;
         end
      end
   end

   // Next state and control
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rounds_in    = rounds_ff;
      diag_in      = diag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      load_out     = 1'b0;
      req_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               for (int k = 0; k < FIELD_COUNT; k++) begin
                  work_in[2*k]     = req_fields[k][31:0];
                  work_in[2*k + 1] = req_fields[k][63:32];
               end
               rounds_in = 4'd0;
               diag_in   = 1'b0;
               // a zero count passes the state through untouched
               state_in  = (count_ff == 4'd0) ? ST_FLUSH : ST_RUN;
            end
         end
         ST_RUN: begin
            work_in = pass_words;
            diag_in = ~diag_ff;
            if (diag_ff) begin
               rounds_in = rounds_ff + 4'd1;
               if (rounds_ff + 4'd1 == count_ff) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            // wait here until the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rounds_ff    <= 4'd0;
         diag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rounds_ff    <= rounds_in;
         diag_ff      <= diag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            count_ff <= csr_write_data;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (load_out) begin
         for (int k = 0; k < FIELD_COUNT; k++) begin
            out_ff[k] <= {work_ff[2*k + 1], work_ff[2*k]};
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_words_0_1   = out_ff[0];
   assign rsp_out_words_2_3   = out_ff[1];
   assign rsp_out_words_4_5   = out_ff[2];
   assign rsp_out_words_6_7   = out_ff[3];
   assign rsp_out_words_8_9   = out_ff[4];
   assign rsp_out_words_10_11 = out_ff[5];
   assign rsp_out_words_12_13 = out_ff[6];
   assign rsp_out_words_14_15 = out_ff[7];

endmodule

// ===== verif/chacha_double_round_permutation_core_tb.sv =====
// Testbench for chacha_double_round_permutation_core: random and directed 512-bit states
// under many double-round counts, checked against an in-bench permutation predictor.
// Depends on chdr_pkg (word and quad types, rotate amounts, reset round count).
module chacha_double_round_permutation_core_tb
   import chdr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // whole state as eight 64-bit fields, field k = {word 2k+1, word 2k}
   typedef logic [FIELD_COUNT-1:0][63:0] fields_type;

   localparam int RANDOM_ITEMS   = 1400;
   localparam int WATCHDOG_LIMIT = 4000;  // idle cycles with no handshake before the watchdog stops the run
   localparam int DRAIN_CYCLES   = 40;    // longer than the latency at the largest round count

   logic clock;
   logic reset          = 1'b1;
   logic req_valid      = 1'b0;
   logic req_ready;
   fields_type req_state = '0;
   logic rsp_valid;
   logic rsp_ready      = 1'b0;
   wire [FIELD_COUNT-1:0][63:0] rsp_state;
   logic csr_write_en   = 1'b0;
   logic [3:0] csr_write_data = '0;

   // round count the block holds right now; only changed while idle
   logic [3:0] round_setting = COUNT_RESET;
   logic [15:0] settings_seen = '0;

   fields_type pending_states[$];   // items not yet offered to the block
   fields_type expected_states[$];  // predicted permutations, oldest first

   int issued_requests   = 0;
   int accepted_requests = 0;
   int results_checked   = 0;
   int error_count       = 0;
   int idle_cycles       = 0;
   int send_gap          = 0;
   int stall_left        = 0;
   bit quiet_mode        = 1'b0;   // no idling on either side while set

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   chacha_double_round_permutation_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_words_0_1       (req_state[0]),
      .req_words_2_3       (req_state[1]),
      .req_words_4_5       (req_state[2]),
      .req_words_6_7       (req_state[3]),
      .req_words_8_9       (req_state[4]),
      .req_words_10_11     (req_state[5]),
      .req_words_12_13     (req_state[6]),
      .req_words_14_15     (req_state[7]),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_words_0_1   (rsp_state[0]),
      .rsp_out_words_2_3   (rsp_state[1]),
      .rsp_out_words_4_5   (rsp_state[2]),
      .rsp_out_words_6_7   (rsp_state[3]),
      .rsp_out_words_8_9   (rsp_state[4]),
      .rsp_out_words_10_11 (rsp_state[5]),
      .rsp_out_words_12_13 (rsp_state[6]),
      .rsp_out_words_14_15 (rsp_state[7]),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data)
   );

   // ---------------------------------------------------------------
   // Permutation predictor
   // ---------------------------------------------------------------
   function automatic word_type rotl(word_type v, int s);
      return (v << s) | (v >> (WORD_WIDTH - s));
   endfunction

   function automatic quad_type quarter_round(quad_type q);
      q.a = q.a + q.b;  q.d = rotl(q.d ^ q.a, ROT_A);
      q.c = q.c + q.d;  q.b = rotl(q.b ^ q.c, ROT_B);
      q.a = q.a + q.b;  q.d = rotl(q.d ^ q.a, ROT_C);
      q.c = q.c + q.d;  q.b = rotl(q.b ^ q.c, ROT_D);
      return q;
   endfunction

   // n double rounds; a count of zero hands the state back untouched
   function automatic fields_type permute_state(fields_type s, logic [3:0] n);
      word_type w [WORD_COUNT];
      quad_type q;
      int ia, ib, ic, id;
      fields_type r;
      for (int k = 0; k < FIELD_COUNT; k++) begin
         w[2*k]   = s[k][31:0];
         w[2*k+1] = s[k][63:32];
      end
      for (int i = 0; i < int'(n); i++) begin
         // pass 0 works on columns, pass 1 on diagonals; the lanes of a pass
         // touch disjoint words, so doing them one after another is exact
         for (int pass = 0; pass < 2; pass++) begin
            for (int lane = 0; lane < LANE_COUNT; lane++) begin
               ia = lane;
               ib = 4  + ((lane + pass) % 4);
               ic = 8  + ((lane + 2 * pass) % 4);
               id = 12 + ((lane + 3 * pass) % 4);
               q.a = w[ia];
               q.b = w[ib];
               q.c = w[ic];
               q.d = w[id];
               q = quarter_round(q);
               w[ia] = q.a;
               w[ib] = q.b;
               w[ic] = q.c;
               w[id] = q.d;
            end
         end
      end
      for (int k = 0; k < FIELD_COUNT; k++)
         r[k] = {w[2*k+1], w[2*k]};
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   // mostly no gap, some short ones, a few long ones; none in quiet mode
   function automatic int pick_idle(int long_max);
      int roll;
      if (quiet_mode)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, long_max);
   endfunction

   // each field fully random most of the time, otherwise drawn from corner
   // values so carries and rotates see all-zero and all-one words too
   function automatic fields_type make_random_state();
      fields_type s;
      for (int k = 0; k < FIELD_COUNT; k++) begin
         if ($urandom_range(0, 4) != 0) begin
            s[k] = {$urandom, $urandom};
         end else begin
            case ($urandom_range(0, 3))
               0: s[k] = 64'h0;
               1: s[k] = '1;
               2: s[k] = 64'h1 << $urandom_range(0, 63);
               default: s[k] = {$urandom, 32'hffff_ffff};
            endcase
         end
      end
      return s;
   endfunction

   // append one item to the pending queue
   function automatic void queue_state(fields_type s);
      pending_states.insert(pending_states.size(), s);
   endfunction

   // true while any item is queued, offered or awaiting its result
   function automatic bit traffic_left();
      return pending_states.size() != 0 || accepted_requests != issued_requests ||
             expected_states.size() != 0;
   endfunction

   // wait for the block to go idle, then load a new round count
   task automatic apply_round_setting(input logic [3:0] n);
      while (traffic_left())
         @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= n;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      round_setting  = n;
      settings_seen[n] = 1'b1;
      // new items are queued just after a rising edge so the driver never
      // races the producer
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Request driver: one item per handshake, fed from pending_states
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accepted_requests == issued_requests) begin
         // previous item (if any) is gone; either idle a while or offer the next
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_states.size() != 0) begin
            req_state <= pending_states.pop_front();
            req_valid <= 1'b1;
            issued_requests++;
            send_gap = pick_idle(50);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result-side backpressure: random stalls, independent of rsp_valid
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_idle(60);
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predicts on accept, checks on result, runs the watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor_blk
      fields_type want;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            // round_setting only changes while nothing is in flight
            expected_states.insert(expected_states.size(),
                                   permute_state(req_state, round_setting));
            accepted_requests++;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected result, nothing pending, got %h", $time, rsp_state);
               error_count++;
            end else begin
               want = expected_states.pop_front();
               for (int k = 0; k < FIELD_COUNT; k++) begin
                  if (rsp_state[k] !== want[k]) begin
                     $display("%0t: out_words_%0d_%0d expected %h got %h",
                              $time, 2*k, 2*k+1, want[k], rsp_state[k]);
                     error_count++;
                  end
               end
               results_checked++;
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_states.size());
            $display("** chacha_double_round_permutation_core: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin : sequence_blk
      int sent;
      int phase_items;
      int phase;
      logic [3:0] n;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset count of ten: corner patterns and single bits at both ends
      settings_seen[COUNT_RESET] = 1'b1;
      queue_state('0);
      queue_state('1);
      queue_state({FIELD_COUNT{64'h5555_5555_5555_5555}});
      queue_state({FIELD_COUNT{64'haaaa_aaaa_aaaa_aaaa}});
      queue_state(fields_type'(1));
      queue_state(fields_type'(1) << (FIELD_COUNT * 64 - 1));

      // zero round count: the state must come back unchanged
      apply_round_setting(4'd0);
      queue_state('1);
      queue_state({FIELD_COUNT{64'h0123_4567_89ab_cdef}});
      queue_state(make_random_state());
      queue_state(make_random_state());

      // largest count
      apply_round_setting(4'd15);
      queue_state('0);
      queue_state('1);
      queue_state(make_random_state());
      queue_state(make_random_state());

      // a single double round
      apply_round_setting(4'd1);
      queue_state('1);
      queue_state(fields_type'(1));
      queue_state(make_random_state());
      queue_state(make_random_state());

      // random phases, each under its own round count; extremes come back
      // regularly, and every third phase runs with no idling at all
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase % 5)
            0: n = 4'd15;
            1: n = 4'd0;
            default: n = 4'($urandom_range(0, 15));
         endcase
         apply_round_setting(n);
         quiet_mode  = (phase % 3 == 2);
         phase_items = $urandom_range(60, 140);
         for (int i = 0; i < phase_items; i++)
            queue_state(make_random_state());
         sent += phase_items;
         phase++;
      end

      // drain, then a margin past the longest latency for stray results
      while (traffic_left())
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d states permuted in %0d phases, %0d distinct round counts",
               accepted_requests, phase + 4, $countones(settings_seen));
      $display("%0d results compared field by field, %0d mismatches",
               results_checked, error_count);
      if (error_count == 0) begin
         $display("** chacha_double_round_permutation_core: PASSED **");
      end else begin
         $display("** chacha_double_round_permutation_core: FAILED **");
      end
      $finish;
   end

endmodule
